FILE: hdl/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and constants for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int DEF_DEPTH = 64;
    localparam int KEY_W     = 32;
    localparam int COUNT_W   = 7;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PU_RD,
        S_PU_CMP,
        S_PO_TOP,
        S_PO_LAST,
        S_PO_GETLAST,
        S_PO_KID,
        S_PO_FIRST,
        S_PO_SIB,
        S_PO_CMP,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PU_RD,
        OP_PU_MOVE,
        OP_PU_PLACE,
        OP_PO_TOP,
        OP_PO_LAST,
        OP_PO_GETLAST,
        OP_PO_KID,
        OP_PO_FIRST,
        OP_PO_SIB,
        OP_PO_MOVE,
        OP_PO_PLACE
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic kid_lt;
        logic sib_lt;
        logic push_above;
        logic pop_above;
    } dp_stat_t;

endpackage

FILE: hdl/bhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for push sift-up and pop sift-down over the heap datapath.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               req_type,
    input  bhpq_pkg::dp_stat_t stat,
    output bhpq_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done
);
    import bhpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_PUSH)
                    begin
                        state_next = stat.full ? S_DONE : S_PU_RD;
                    end
                    else
                    begin
                        state_next = stat.empty ? S_DONE : S_PO_TOP;
                    end
                end
            end
            S_PU_RD:      state_next = stat.pos_zero ? S_DONE : S_PU_CMP;
            S_PU_CMP:     state_next = stat.push_above ? S_PU_RD : S_DONE;
            S_PO_TOP:     state_next = S_PO_LAST;
            S_PO_LAST:    state_next = S_PO_GETLAST;
            S_PO_GETLAST: state_next = S_PO_KID;
            S_PO_KID:     state_next = stat.kid_lt ? S_PO_FIRST : S_DONE;
            S_PO_FIRST:   state_next = stat.sib_lt ? S_PO_SIB : S_PO_CMP;
            S_PO_SIB:     state_next = S_PO_CMP;
            S_PO_CMP:     state_next = stat.pop_above ? S_PO_KID : S_DONE;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (req_type == REQ_PUSH)
                    begin
                        cmd.code = stat.full ? ST_FULL : ST_OK;
                    end
                    else
                    begin
                        cmd.code = stat.empty ? ST_EMPTY : ST_OK;
                    end
                end
            end
            S_PU_RD:      cmd.op = stat.pos_zero ? OP_PU_PLACE : OP_PU_RD;
            S_PU_CMP:     cmd.op = stat.push_above ? OP_PU_MOVE : OP_PU_PLACE;
            S_PO_TOP:     cmd.op = OP_PO_TOP;
            S_PO_LAST:    cmd.op = OP_PO_LAST;
            S_PO_GETLAST: cmd.op = OP_PO_GETLAST;
            S_PO_KID:     cmd.op = stat.kid_lt ? OP_PO_KID : OP_PO_PLACE;
            S_PO_FIRST:   cmd.op = OP_PO_FIRST;
            S_PO_SIB:     cmd.op = OP_PO_SIB;
            S_PO_CMP:     cmd.op = stat.pop_above ? OP_PO_MOVE : OP_PO_PLACE;
            S_DONE:       cmd.op = OP_NONE;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

FILE: hdl/bhpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_datapath
// Heap memory, index registers, key registers, count and order mode.
// ----------------------------------------------------------------------------
module bhpq_datapath #(
    parameter int DEPTH = bhpq_pkg::DEF_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bhpq_pkg::dp_cmd_t                  cmd,
    input  logic signed [bhpq_pkg::KEY_W-1:0]  key,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wdata,
    output bhpq_pkg::dp_stat_t                 stat,
    output logic signed [bhpq_pkg::KEY_W-1:0]  top_key,
    output logic [1:0]                         status,
    output logic [bhpq_pkg::COUNT_W-1:0]       entry_count,
    output logic                               is_full,
    output logic                               is_empty
);
    import bhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = AW + 2;

    function automatic logic ranks_above(input logic largest,
                                         input logic signed [KEY_W-1:0] a,
                                         input logic signed [KEY_W-1:0] b);
        return largest ? (a > b) : (a < b);
    endfunction

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;

    logic                    mode_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           pos_next;
    logic [KW-1:0]           kid_reg;
    logic [KW-1:0]           kid_next;
    logic [AW-1:0]           best_idx_reg;
    logic [AW-1:0]           best_idx_next;
    logic signed [KEY_W-1:0] best_reg;
    logic signed [KEY_W-1:0] best_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic signed [KEY_W-1:0] last_reg;
    logic signed [KEY_W-1:0] last_next;
    logic signed [KEY_W-1:0] top_reg;
    logic signed [KEY_W-1:0] top_next;
    status_t                 status_reg;
    status_t                 status_next;

    logic [AW-1:0]           parent;
    logic [KW-1:0]           kid_sib;
    logic [KW-1:0]           cnt_wide;

    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign kid_sib  = kid_reg + KW'(1);
    assign cnt_wide = KW'(cnt_reg);

    always_comb
    begin
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = key_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        kid_next      = kid_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        key_next      = key_reg;
        last_next     = last_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                key_next    = key;
                top_next    = '0;
                status_next = cmd.code;
                pos_next    = cnt_reg[AW-1:0];
            end
            OP_PU_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = parent;
            end
            OP_PU_MOVE:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                pos_next = parent;
            end
            OP_PU_PLACE:
            begin
                wr_en    = 1'b1;
                wr_data  = key_reg;
                cnt_next = cnt_reg + CW'(1);
            end
            OP_PO_TOP:
            begin
                rd_en    = 1'b1;
                rd_addr  = '0;
                cnt_next = cnt_reg - CW'(1);
                pos_next = '0;
                kid_next = KW'(1);
            end
            OP_PO_LAST:
            begin
                top_next = rd_data_reg;
                rd_en    = 1'b1;
                rd_addr  = cnt_reg[AW-1:0];
            end
            OP_PO_GETLAST:
            begin
                last_next = rd_data_reg;
            end
            OP_PO_KID:
            begin
                rd_en   = 1'b1;
                rd_addr = kid_reg[AW-1:0];
            end
            OP_PO_FIRST:
            begin
                best_next     = rd_data_reg;
                best_idx_next = kid_reg[AW-1:0];
                // sibling read is ignored when it lies past the tail
                rd_en         = 1'b1;
                rd_addr       = kid_sib[AW-1:0];
            end
            OP_PO_SIB:
            begin
                if (ranks_above(mode_reg, rd_data_reg, best_reg))
                begin
                    best_next     = rd_data_reg;
                    best_idx_next = kid_sib[AW-1:0];
                end
            end
            OP_PO_MOVE:
            begin
                wr_en    = 1'b1;
                wr_data  = best_reg;
                pos_next = best_idx_reg;
                kid_next = KW'({best_idx_reg, 1'b1});
            end
            OP_PO_PLACE:
            begin
                wr_en   = 1'b1;
                wr_data = last_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            mode_reg   <= 1'b1;
            status_reg <= ST_OK;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            // order mode changes only while the heap holds nothing
            if (cfg_wr_en && (cnt_reg == '0))
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        kid_reg      <= kid_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        key_reg      <= key_next;
        last_reg     <= last_next;
        top_reg      <= top_next;
    end

    assign stat.full       = (cnt_reg == CW'(DEPTH));
    assign stat.empty      = (cnt_reg == '0);
    assign stat.pos_zero   = (pos_reg == '0);
    assign stat.kid_lt     = (kid_reg < cnt_wide);
    assign stat.sib_lt     = (kid_sib < cnt_wide);
    assign stat.push_above = ranks_above(mode_reg, key_reg, rd_data_reg);
    assign stat.pop_above  = ranks_above(mode_reg, best_reg, last_reg);

    assign top_key     = top_reg;
    assign status      = status_reg;
    assign entry_count = COUNT_W'(cnt_reg);
    assign is_full     = stat.full;
    assign is_empty    = stat.empty;

endmodule

FILE: hdl/binary_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top
// Binary heap priority queue of signed keys, max-first or min-first order.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         req_type, key
//  result    done (one cycle)     top_key, status, entry_count, is_full,
//                                 is_empty
//  config    cfg_wr_en            cfg_wdata (order mode, 1 = largest first)
//
//  transaction steps, registered-read memory:
//  push: read the parent and move it down until the root or a compare stops it
//  pop: read root and last key, move the better child up until a leaf or a compare
//  dropped push or empty pop: straight to done
//  reset clears the count and sets largest-first order; no clearing pass
//  results are not stalled: done is high for one cycle per transaction
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top #(
    parameter int DEPTH = bhpq_pkg::DEF_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic signed [bhpq_pkg::KEY_W-1:0]  key,
    output logic                               done,
    output logic signed [bhpq_pkg::KEY_W-1:0]  top_key,
    output logic [1:0]                         status,
    output logic [bhpq_pkg::COUNT_W-1:0]       entry_count,
    output logic                               is_full,
    output logic                               is_empty,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wdata
);
    import bhpq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    bhpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key         (key),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wdata   (cfg_wdata),
        .stat        (stat),
        .top_key     (top_key),
        .status      (status),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

    // one strobe per transaction
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (is_full && (top_key == '0)))
        else $error("dropped push reported without full heap");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (is_empty && (top_key == '0)))
        else $error("empty pop reported with keys present or nonzero key");

endmodule

FILE: bench/heap_mirror_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_mirror_pkg
// Scoreboard for the heap priority queue bench. A behavioral copy of the heap
// predicts the result of every accepted transaction, and each strobed result
// is checked against the oldest prediction.
// ----------------------------------------------------------------------------
package heap_mirror_pkg;

    import bhpq_pkg::*;

    localparam int CAP = DEF_DEPTH;

    typedef struct packed {
        logic signed [KEY_W-1:0] top_key;
        status_t                 code;
        logic [COUNT_W-1:0]      count;
        logic                    full;
        logic                    empty;
    } heap_result_t;

    class heap_mirror;

        logic signed [KEY_W-1:0] slots [CAP];
        int                      fill;
        bit                      largest_first;
        heap_result_t            awaited [$];
        int unsigned             n_checked;
        int unsigned             n_bad;
        int unsigned             n_pushes;
        int unsigned             n_pops;
        int unsigned             n_dropped;
        int unsigned             n_starved;

        function new();
            fill          = 0;
            largest_first = 1'b1;
            n_checked     = 0;
            n_bad         = 0;
            n_pushes      = 0;
            n_pops        = 0;
            n_dropped     = 0;
            n_starved     = 0;
        endfunction

        // order changes only land on an empty heap
        function void write_order(logic v);
            if (fill == 0)
                largest_first = v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function bit outranks(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
            return largest_first ? (a > b) : (a < b);
        endfunction

        function void sift_up(logic signed [KEY_W-1:0] k);
            int pos;
            int up;
            bit settled;
            pos     = fill;
            settled = 1'b0;
            while (pos > 0 && !settled)
            begin
                up = (pos - 1) / 2;
                if (outranks(k, slots[up]))
                begin
                    slots[pos] = slots[up];
                    pos        = up;
                end
                else
                    settled = 1'b1;
            end
            slots[pos] = k;
            fill++;
        endfunction

        function logic signed [KEY_W-1:0] remove_root();
            logic signed [KEY_W-1:0] root;
            logic signed [KEY_W-1:0] last;
            int pos;
            int kid;
            bit settled;
            root = slots[0];
            fill--;
            last    = slots[fill];
            pos     = 0;
            kid     = 1;
            settled = 1'b0;
            while (kid < fill && !settled)
            begin
                // pick the better child, equal keys stay put
                if (kid + 1 < fill && outranks(slots[kid + 1], slots[kid]))
                    kid++;
                if (outranks(slots[kid], last))
                begin
                    slots[pos] = slots[kid];
                    pos        = kid;
                    kid        = 2 * pos + 1;
                end
                else
                    settled = 1'b1;
            end
            slots[pos] = last;
            return root;
        endfunction

        function void note_request(req_t op, logic signed [KEY_W-1:0] k);
            heap_result_t res;
            res.top_key = '0;
            res.code    = ST_OK;
            if (op == REQ_PUSH)
            begin
                n_pushes++;
                if (fill >= CAP)
                begin
                    res.code = ST_FULL;
                    n_dropped++;
                end
                else
                    sift_up(k);
            end
            else
            begin
                n_pops++;
                if (fill == 0)
                begin
                    res.code = ST_EMPTY;
                    n_starved++;
                end
                else
                    res.top_key = remove_root();
            end
            res.count = fill[COUNT_W-1:0];
            res.full  = (fill == CAP);
            res.empty = (fill == 0);
            awaited.push_back(res);
        endfunction

        function void check_result(logic signed [KEY_W-1:0] top_key, logic [1:0] code,
                                   logic [COUNT_W-1:0] count, logic full, logic empty);
            heap_result_t exp;
            if (awaited.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: result with nothing outstanding: top=%0d status=%0d count=%0d",
                             $realtime, top_key, code, count);
                return;
            end
            exp = awaited.pop_front();
            n_checked++;
            if (top_key !== exp.top_key || code !== exp.code || count !== exp.count ||
                full !== exp.full || empty !== exp.empty)
            begin
                n_bad++;
                if (n_bad <= 10)
                begin
                    $display("%0t: mismatch exp top=%0d st=%0d cnt=%0d f=%0b e=%0b",
                             $realtime, exp.top_key, exp.code, exp.count, exp.full,
                             exp.empty);
                    $display("    got top=%0d st=%0d cnt=%0d f=%0b e=%0b",
                             top_key, code, count, full, empty);
                end
            end
        endfunction

    endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the binary heap priority queue. Directed pushes and pops cover
// key extremes, equal keys, empty pops and ignored order writes; random
// fill/drain runs in both orderings reach the full heap and dropped pushes,
// with sender gaps of varying density.
// ----------------------------------------------------------------------------
module tb_top;

    import bhpq_pkg::*;
    import heap_mirror_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic signed [KEY_W-1:0]  key;
    logic                     done;
    logic signed [KEY_W-1:0]  top_key;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_full;
    logic                     is_empty;
    logic                     cfg_wr_en;
    logic                     cfg_wdata;

    heap_mirror mirror;

    binary_heap_priority_queue_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key         (key),
        .done        (done),
        .top_key     (top_key),
        .status      (status),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // results first; a done never shares an edge with an accepted request, as busy is high with done
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                mirror.check_result(top_key, status, entry_count, is_full, is_empty);
            if (cfg_wr_en)
                mirror.write_order(cfg_wdata);
            if (start && !busy)
                mirror.note_request(req_t'(req_type), key);
        end
    end

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(9)) inside
            [0:3]:      return $urandom;
            // narrow range so equal keys pile up
            [4:6]:      return $signed($urandom_range(16)) - 8;
            7:          return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            8:          return $urandom_range(1) ? 32'sh0 : -32'sh1;
            default:    return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                                 : 32'sh80000000 + $urandom_range(3);
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input req_t op, input logic signed [KEY_W-1:0] k);
        start    <= 1'b1;
        req_type <= op;
        key      <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < pct)
                @(negedge clk);
        end
    endtask

    task automatic write_order(input logic v);
        start <= 1'b0;
        @(negedge clk);
        while (mirror.pending() != 0 || busy)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain(input int pct);
        while (mirror.fill != 0)
        begin
            sender_gap(pct);
            send_item(REQ_POP, rand_key());
        end
    endtask

    // biased toward pushes until full, then toward pops until empty
    task automatic run_phase(input int pct, input int n);
        bit filling;
        filling = 1'b1;
        repeat (n)
        begin
            if (mirror.fill == CAP && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (mirror.fill == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            sender_gap(pct);
            if (($urandom_range(99) < 88) == filling)
                send_item(REQ_PUSH, rand_key());
            else
                send_item(REQ_POP, rand_key());
        end
        drain(pct);
    endtask

    initial
    begin
        mirror    = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = 1'b0;
        key       = '0;
        cfg_wr_en = 1'b0;
        cfg_wdata = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // largest first after reset
        send_item(REQ_POP, 32'sh12345678);
        send_item(REQ_PUSH, 32'sh7fffffff);
        send_item(REQ_PUSH, 32'sh80000000);
        send_item(REQ_PUSH, 32'sh0);
        send_item(REQ_PUSH, -32'sh1);
        send_item(REQ_PUSH, 32'sh5);
        send_item(REQ_PUSH, 32'sh5);
        send_item(REQ_PUSH, 32'sh1);
        // heap not empty, so the order must not change
        write_order(1'b0);
        repeat (8)
            send_item(REQ_POP, rand_key());

        write_order(1'b0);
        send_item(REQ_PUSH, 32'sh7fffffff);
        send_item(REQ_PUSH, 32'sh80000000);
        send_item(REQ_PUSH, -32'sh3);
        send_item(REQ_PUSH, -32'sh3);
        send_item(REQ_PUSH, 32'sh0);
        repeat (4)
            send_item(REQ_POP, 32'shffffffff);
        drain(0);

        write_order(1'b1);
        run_phase(0, 100);
        write_order(1'b0);
        run_phase(74, 100);
        write_order(1'b1);
        run_phase(28, 100);

        start <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("ran %0d pushes and %0d pops in both orderings",
                 mirror.n_pushes, mirror.n_pops);
        $display("%0d pushes on a full heap, %0d pops on an empty one",
                 mirror.n_dropped, mirror.n_starved);
        $display("%0d results checked, %0d mismatches", mirror.n_checked, mirror.n_bad);
        if (mirror.n_bad == 0 && mirror.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", mirror.pending());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bhpq_pkg.sv
hdl/bhpq_ctrl.sv
hdl/bhpq_datapath.sv
hdl/binary_heap_priority_queue_top.sv
bench/heap_mirror_pkg.sv
bench/tb_top.sv
